### src/lzfw_pkg.sv
// Package with the shared types and constants of the flag-word decompressor.
`timescale 1ns / 1ps

package lzfw_pkg;

  typedef logic [7:0] byte_t;

  localparam int unsigned WINDOW_LOG_DEFAULT = 14;
  localparam int unsigned OFFSET_BASE        = 14;
  localparam int unsigned MIN_MATCH          = 3;
  localparam int unsigned FLAG_TOP           = 31;
  localparam int unsigned DIST_WIDTH         = 15;
  localparam int unsigned LEN_WIDTH          = 6;

endpackage

### src/lzfw_if.sv
// Valid/ready stream interfaces for the compressed input and the decompressed output.
`timescale 1ns / 1ps

interface lzfw_in_if;
  logic           valid;
  logic           ready;
  lzfw_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzfw_out_if;
  logic           valid;
  logic           ready;
  lzfw_pkg::byte_t out_byte;
  logic           last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

### src/lz_flag_word_decompressor_top.sv
// Top level of the LZSS flag-word decompressor with its history window memory.
`timescale 1ns / 1ps

// The block takes one compressed byte per transfer and returns decompressed bytes with
// last_of_run set on the final byte caused by each input byte. A match low byte holds
// off further input until its copy is done, since every copied byte goes through the
// single registered read port of the history window and one byte is written back per
// cycle while the output is not stalled. The window needs no clearing pass after
// reset: the write pointer and a wrap flag mark which entries have been written, and
// unwritten entries read as zero. A stalled output holds the copy in place. A new
// stream needs a reset.
module lz_flag_word_decompressor_top #(
  parameter int unsigned WINDOW_LOG = lzfw_pkg::WINDOW_LOG_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lzfw_in_if.sink      in_i,
  lzfw_out_if.source   out_o
);

  localparam int unsigned WinSize = 1 << WINDOW_LOG;
  localparam int unsigned DistW   = (WINDOW_LOG > lzfw_pkg::DIST_WIDTH) ?
                                    WINDOW_LOG : lzfw_pkg::DIST_WIDTH;
  localparam int unsigned LenW    = lzfw_pkg::LEN_WIDTH;

  localparam logic [1:0] PH_HEADER   = 2'd0;
  localparam logic [1:0] PH_FLAG     = 2'd1;
  localparam logic [1:0] PH_TOKEN    = 2'd2;
  localparam logic [1:0] PH_MATCH_LO = 2'd3;

  typedef logic [WINDOW_LOG-1:0] addr_t;

  logic [1:0]       phase_q, phase_d;
  logic [1:0]       bcnt_q, bcnt_d;
  logic [31:0]      flag_word_q, flag_word_d;
  logic [4:0]       flag_idx_q, flag_idx_d;
  logic [3:0]       obits_q, obits_d;
  lzfw_pkg::byte_t  hi_q, hi_d;
  addr_t            wp_q, wp_d;
  logic             wrapped_q, wrapped_d;
  addr_t            rp_q, rp_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic             s2_q, s2_d;
  logic             s2_last_q, s2_last_d;
  logic             out_valid_q, out_valid_d;
  lzfw_pkg::byte_t  out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  lzfw_pkg::byte_t  mem_q [WinSize];
  lzfw_pkg::byte_t  rd_q;
  logic             rd_zero_q;

  logic             accept, busy, out_free, cur_bit, produces;
  logic             lit, emit, rd_re, rd_valid, mem_we;
  lzfw_pkg::byte_t  mem_wdata, copy_byte;
  logic [15:0]      word, mask;
  logic [LenW-1:0]  len;
  logic [DistW-1:0] match_dist;
  logic [4:0]       len_m3;
  logic [1:0]       after_tok;

  assign busy     = (cnt_q != '0) || s2_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign cur_bit  = flag_word_q[flag_idx_q];
  assign produces = (phase_q == PH_TOKEN) && !cur_bit;
  assign in_i.ready = !busy && (out_free || !produces);
  assign accept   = in_i.valid && in_i.ready;

  assign lit       = accept && produces;
  assign emit      = s2_q && out_free;
  assign copy_byte = rd_zero_q ? 8'd0 : rd_q;
  assign mem_we    = lit || emit;
  assign mem_wdata = lit ? in_i.in_byte : copy_byte;
  assign rd_re     = (cnt_q != '0) && (!s2_q || emit);
  assign rd_valid  = wrapped_q || (rp_q < wp_q) || (emit && (rp_q == wp_q));

  assign word       = {hi_q, in_i.in_byte};
  assign mask       = ~(16'hFFFF << obits_q);
  assign len_m3     = 5'(word >> obits_q);
  assign len        = LenW'(len_m3) + LenW'(lzfw_pkg::MIN_MATCH);
  assign match_dist = DistW'({2'b00, word[13:0] & mask[13:0]}) + DistW'(1);

  always_comb begin
    after_tok = (flag_idx_d <= 5'd1) ? PH_FLAG : PH_TOKEN;
  end

  always_comb begin
    phase_d     = phase_q;
    bcnt_d      = bcnt_q;
    flag_word_d = flag_word_q;
    flag_idx_d  = flag_idx_q;
    obits_d     = obits_q;
    hi_d        = hi_q;
    rp_d        = rp_q;
    cnt_d       = cnt_q;
    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          bcnt_d = bcnt_q + 2'd1;
          if (bcnt_q == 2'd3) begin
            phase_d = after_tok;
          end
        end
        PH_FLAG: begin
          flag_word_d = {flag_word_q[23:0], in_i.in_byte};
          bcnt_d      = bcnt_q + 2'd1;
          if (bcnt_q == 2'd3) begin
            flag_idx_d = 5'(lzfw_pkg::FLAG_TOP);
            obits_d    = 4'(lzfw_pkg::OFFSET_BASE) - {2'b00, flag_word_d[1:0]};
            phase_d    = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          flag_idx_d = flag_idx_q - 5'd1;
          if (cur_bit) begin
            hi_d    = in_i.in_byte;
            phase_d = PH_MATCH_LO;
          end else begin
            phase_d = after_tok;
          end
        end
        PH_MATCH_LO: begin
          rp_d    = WINDOW_LOG'(DistW'(wp_q) - match_dist);
          cnt_d   = len;
          phase_d = after_tok;
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
    if (rd_re) begin
      rp_d  = rp_q + addr_t'(1);
      cnt_d = cnt_q - LenW'(1);
    end
  end

  always_comb begin
    s2_d      = s2_q;
    s2_last_d = s2_last_q;
    if (emit) begin
      s2_d = 1'b0;
    end
    if (rd_re) begin
      s2_d      = 1'b1;
      s2_last_d = (cnt_q == LenW'(1));
    end
    wp_d      = mem_we ? wp_q + addr_t'(1) : wp_q;
    wrapped_d = wrapped_q || (mem_we && (wp_q == '1));
    out_valid_d = out_valid_q && !out_o.ready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (lit) begin
      out_valid_d = 1'b1;
      out_byte_d  = in_i.in_byte;
      out_last_d  = 1'b1;
    end else if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = copy_byte;
      out_last_d  = s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      bcnt_q      <= '0;
      flag_word_q <= '0;
      flag_idx_q  <= '0;
      obits_q     <= 4'(lzfw_pkg::OFFSET_BASE);
      hi_q        <= '0;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      rp_q        <= '0;
      cnt_q       <= '0;
      s2_q        <= 1'b0;
      s2_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bcnt_q      <= bcnt_d;
      flag_word_q <= flag_word_d;
      flag_idx_q  <= flag_idx_d;
      obits_q     <= obits_d;
      hi_q        <= hi_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      rp_q        <= rp_d;
      cnt_q       <= cnt_d;
      s2_q        <= s2_d;
      s2_last_q   <= s2_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= mem_wdata;
    end
  end

  // A read of the entry written in the same cycle returns the new byte.
  always_ff @(posedge clk_i) begin
    if (rd_re) begin
      rd_q      <= (mem_we && (rp_q == wp_q)) ? mem_wdata : mem_q[rp_q];
      rd_zero_q <= !rd_valid;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.last_of_run = out_last_q;

  a_copy_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q && !emit) |=> (s2_q && $stable(rd_q) && $stable(rd_zero_q)))
    else $error("Copied byte changed while the output was stalled.");

  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (phase_q != PH_MATCH_LO))
    else $error("Copy in progress while a match low byte is still expected.");

  a_last_ends_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && s2_last_q) |=> (cnt_q == '0) && !s2_q)
    else $error("Copy continued after its last byte.");

  a_wrap_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrapped_q |=> wrapped_q)
    else $error("Window fill mark was lost.");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(lit && s2_q))
    else $error("Literal written while a copy was still in flight.");

endmodule
